// File: design/csnh_pkg.sv
package csnh_pkg;

  // Channel scale and rounding offset
  localparam int CHANNEL_FULL_SCALE = 1023;
  localparam int HALF_FS            = CHANNEL_FULL_SCALE / 2;

  // Field widths
  localparam int CH_W       = 10;
  localparam int NORM_W     = 8;
  localparam int HUE_W      = 9;
  localparam int PCT_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Arithmetic constants
  localparam int CH_MAX     = 1023;
  localparam int PCT_SCALE  = 100;
  localparam int BYTE_SCALE = 255;
  localparam int HUE_STEP   = 60;
  localparam int HUE_GREEN  = 120;
  localparam int HUE_BLUE   = 240;
  localparam int HUE_WRAP   = 360;

  // Divider sizing: largest dividend is the rounded 0..255 brightness
  localparam int NUM_MAX = CH_MAX * BYTE_SCALE + HALF_FS;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int STEPS   = (NUM_W + 1) / 2;
  localparam int QW      = 2 * STEPS;
  localparam int FS_W    = $clog2(CHANNEL_FULL_SCALE + 1);
  localparam int DEN_W   = (FS_W > CH_W) ? FS_W : CH_W;
  localparam int CNT_W   = $clog2(STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REFL_ONLY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LO  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HI  = CFG_IDX_W'(5);

  // Divisions run on the shared unit
  typedef enum logic [2:0] {
    OP_NORM,
    OP_VPCT,
    OP_VBYTE,
    OP_SAT,
    OP_HUE
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_RUN  = 5'b00100,
    ST_WB   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic              sensor_present;
    logic [CH_W-1:0]   reflection_raw;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
  } in_item_t;

  typedef struct packed {
    logic              ready_res;
    logic [CH_W-1:0]   reflection_out;
    logic [NORM_W-1:0] normalized_out;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [HUE_W-1:0]  hue_deg;
    logic [PCT_W-1:0]  saturation_pct;
    logic [PCT_W-1:0]  value_pct;
    logic [BYTE_W-1:0] value_byte;
  } out_item_t;

endpackage

// File: design/csnh_if.sv
interface csnh_in_if;
  logic                valid;
  logic                ready;
  csnh_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csnh_out_if;
  logic                valid;
  logic                ready;
  csnh_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/color_sample_normalize_hsv.sv
// Each sample runs its divisions one after another on the shared divider (2 quotient
// bits a cycle, 9 steps plus a write-back per division): five in full mode (three with
// equal channels), one in reflection-only mode, none with the sensor absent. A new sample
// is taken only once the last is finished: in_ch.ready is high only while idle, a waiting
// result aside. Reset (rst_n low, synchronous): control, level and held registers
// to their reset levels, held values zero; divider and payload registers are not reset.
module color_sample_normalize_hsv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [csnh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csnh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  csnh_in_if.sink                            in_ch,
  csnh_out_if.source                         out_ch
);

  localparam int QW    = csnh_pkg::QW;
  localparam int DEN_W = csnh_pkg::DEN_W;
  localparam int CNT_W = csnh_pkg::CNT_W;
  localparam int CH_W  = csnh_pkg::CH_W;

  // Control and held state
  csnh_pkg::state_t state_r, state_nxt;
  csnh_pkg::op_t    op_r, op_nxt, op_sel;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CH_W-1:0]                 black_r, black_nxt;
  logic [CH_W-1:0]                 white_r, white_nxt;
  logic                            ro_r, ro_nxt;
  logic [csnh_pkg::NORM_W-1:0]     fallback_r, fallback_nxt;
  logic [csnh_pkg::NORM_W-1:0]     clamp_lo_r, clamp_lo_nxt;
  logic [csnh_pkg::NORM_W-1:0]     clamp_hi_r, clamp_hi_nxt;

  logic [CH_W-1:0]                 held_refl_r, held_refl_nxt;
  logic [csnh_pkg::NORM_W-1:0]     held_norm_r, held_norm_nxt;
  logic [CH_W-1:0]                 held_red_r, held_red_nxt;
  logic [CH_W-1:0]                 held_green_r, held_green_nxt;
  logic [CH_W-1:0]                 held_blue_r, held_blue_nxt;
  logic [csnh_pkg::HUE_W-1:0]      held_hue_r, held_hue_nxt;
  logic [csnh_pkg::PCT_W-1:0]      held_sat_r, held_sat_nxt;
  logic [csnh_pkg::PCT_W-1:0]      held_vpct_r, held_vpct_nxt;
  logic [csnh_pkg::BYTE_W-1:0]     held_vbyte_r, held_vbyte_nxt;

  // Divider datapath
  logic [QW-1:0]    num_r, num_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic             present_r, present_nxt;
  csnh_pkg::out_item_t out_data_r, out_data_nxt;

  logic             in_acc;
  logic             out_free;
  logic             load_div;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem_in,
                                              input logic             bin,
                                              input logic [DEN_W-1:0] den_in);
    logic [DEN_W:0] t;
    t = {rem_in, bin};
    if (t >= {1'b0, den_in}) begin
      div_step = {1'b1, DEN_W'(t - {1'b0, den_in})};
    end else begin
      div_step = {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  // Channel extremes of the held sample
  logic [CH_W-1:0] mx, mn, delta;
  always_comb begin
    mx = held_red_r;
    if (held_green_r > mx) mx = held_green_r;
    if (held_blue_r > mx) mx = held_blue_r;
    mn = held_red_r;
    if (held_green_r < mn) mn = held_green_r;
    if (held_blue_r < mn) mn = held_blue_r;
    delta = mx - mn;
  end

  // Hue sector: signed channel difference and base angle
  logic signed [CH_W:0] hue_diff;
  logic [9:0]           hue_base;
  logic [CH_W-1:0]      hue_mag;
  always_comb begin
    priority if (mx == held_red_r) begin
      hue_diff = $signed({1'b0, held_green_r}) - $signed({1'b0, held_blue_r});
      hue_base = '0;
    end else if (mx == held_green_r) begin
      hue_diff = $signed({1'b0, held_blue_r}) - $signed({1'b0, held_red_r});
      hue_base = 10'(csnh_pkg::HUE_GREEN);
    end else begin
      hue_diff = $signed({1'b0, held_red_r}) - $signed({1'b0, held_green_r});
      hue_base = 10'(csnh_pkg::HUE_BLUE);
    end
    hue_mag = hue_diff[CH_W] ? CH_W'(-hue_diff) : hue_diff[CH_W-1:0];
  end

  // Reflection offset against black
  logic signed [CH_W:0] refl_diff;
  logic [CH_W-1:0]      refl_mag;
  logic                 range_empty;
  assign refl_diff   = $signed({1'b0, held_refl_r}) - $signed({1'b0, black_r});
  assign refl_mag    = refl_diff[CH_W] ? CH_W'(-refl_diff) : refl_diff[CH_W-1:0];
  assign range_empty = (white_r <= black_r);

  // Operand select for the division about to start
  logic [QW-1:0]    op_num;
  logic [DEN_W-1:0] op_den;
  logic             op_neg;
  always_comb begin
    op_num = '0;
    op_den = '0;
    op_neg = 1'b0;
    unique case (op_sel)
      csnh_pkg::OP_NORM: begin
        op_num = QW'(refl_mag) * QW'(csnh_pkg::PCT_SCALE);
        op_den = DEN_W'(white_r - black_r);
        op_neg = refl_diff[CH_W];
      end
      csnh_pkg::OP_VPCT: begin
        op_num = QW'(mx) * QW'(csnh_pkg::PCT_SCALE) + QW'(csnh_pkg::HALF_FS);
        op_den = DEN_W'(csnh_pkg::CHANNEL_FULL_SCALE);
      end
      csnh_pkg::OP_VBYTE: begin
        op_num = QW'(mx) * QW'(csnh_pkg::BYTE_SCALE) + QW'(csnh_pkg::HALF_FS);
        op_den = DEN_W'(csnh_pkg::CHANNEL_FULL_SCALE);
      end
      csnh_pkg::OP_SAT: begin
        op_num = QW'(delta) * QW'(csnh_pkg::PCT_SCALE) + QW'(mx >> 1);
        op_den = DEN_W'(mx);
      end
      csnh_pkg::OP_HUE: begin
        op_num = QW'(hue_mag) * QW'(csnh_pkg::HUE_STEP);
        op_den = DEN_W'(delta);
        op_neg = hue_diff[CH_W];
      end
      default: begin
        op_num = '0;
      end
    endcase
  end

  // Two restoring steps per cycle
  logic [DEN_W:0] step1, step2;
  assign step1 = div_step(rem_r, num_r[QW-1], den_r);
  assign step2 = div_step(step1[DEN_W-1:0], num_r[QW-2], den_r);

  // Write-back values from the finished quotient
  logic signed [QW:0] nq, lo_s, hi_s, nq_lo, nq_cl;
  logic [csnh_pkg::NORM_W-1:0] norm_res;
  logic signed [9:0]  hq, hsum, hwrap;
  always_comb begin
    nq    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    lo_s  = $signed((QW+1)'(clamp_lo_r));
    hi_s  = $signed((QW+1)'(clamp_hi_r));
    nq_lo = (nq < lo_s) ? lo_s : nq;
    nq_cl = (nq_lo > hi_s) ? hi_s : nq_lo;
    norm_res = range_empty ? fallback_r : nq_cl[csnh_pkg::NORM_W-1:0];
    hq    = neg_r ? -$signed({3'b000, quo_r[6:0]}) : $signed({3'b000, quo_r[6:0]});
    hsum  = $signed(hue_base) + hq;
    hwrap = (hsum < 0) ? hsum + 10'sd360 : hsum;
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    present_nxt    = present_r;
    out_data_nxt   = out_data_r;
    held_refl_nxt  = held_refl_r;
    held_norm_nxt  = held_norm_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    held_blue_nxt  = held_blue_r;
    held_hue_nxt   = held_hue_r;
    held_sat_nxt   = held_sat_r;
    held_vpct_nxt  = held_vpct_r;
    held_vbyte_nxt = held_vbyte_r;
    load_div       = 1'b0;
    op_sel         = op_r;

    unique case (state_r)
      csnh_pkg::ST_IDLE: begin
        if (in_acc) begin
          present_nxt = in_ch.data.sensor_present;
          if (in_ch.data.sensor_present) begin
            held_refl_nxt = in_ch.data.reflection_raw;
            if (!ro_r) begin
              held_red_nxt   = in_ch.data.red_in;
              held_green_nxt = in_ch.data.green_in;
              held_blue_nxt  = in_ch.data.blue_in;
            end
            op_nxt    = csnh_pkg::OP_NORM;
            state_nxt = csnh_pkg::ST_LOAD;
          end else begin
            // Full mode with no sensor: drop every held value
            if (!ro_r) begin
              held_refl_nxt  = '0;
              held_norm_nxt  = '0;
              held_red_nxt   = '0;
              held_green_nxt = '0;
              held_blue_nxt  = '0;
              held_hue_nxt   = '0;
              held_sat_nxt   = '0;
              held_vpct_nxt  = '0;
              held_vbyte_nxt = '0;
            end
            state_nxt = csnh_pkg::ST_DONE;
          end
        end
      end
      csnh_pkg::ST_LOAD: begin
        load_div  = 1'b1;
        state_nxt = csnh_pkg::ST_RUN;
      end
      csnh_pkg::ST_RUN: begin
        num_nxt = num_r << 2;
        quo_nxt = {quo_r[QW-3:0], step1[DEN_W], step2[DEN_W]};
        rem_nxt = step2[DEN_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(csnh_pkg::STEPS - 1)) begin
          state_nxt = csnh_pkg::ST_WB;
        end
      end
      csnh_pkg::ST_WB: begin
        state_nxt = csnh_pkg::ST_RUN;
        load_div  = 1'b1;
        unique case (op_r)
          csnh_pkg::OP_NORM: begin
            held_norm_nxt = norm_res;
            if (ro_r) begin
              state_nxt = csnh_pkg::ST_DONE;
              load_div  = 1'b0;
            end else begin
              op_nxt = csnh_pkg::OP_VPCT;
            end
          end
          csnh_pkg::OP_VPCT: begin
            held_vpct_nxt = (quo_r > QW'(csnh_pkg::PCT_SCALE)) ?
                            csnh_pkg::PCT_W'(csnh_pkg::PCT_SCALE) :
                            quo_r[csnh_pkg::PCT_W-1:0];
            op_nxt = csnh_pkg::OP_VBYTE;
          end
          csnh_pkg::OP_VBYTE: begin
            held_vbyte_nxt = (quo_r > QW'(csnh_pkg::BYTE_SCALE)) ?
                             csnh_pkg::BYTE_W'(csnh_pkg::BYTE_SCALE) :
                             quo_r[csnh_pkg::BYTE_W-1:0];
            // Equal channels: no hue and no saturation
            if (delta == '0) begin
              held_sat_nxt = '0;
              held_hue_nxt = '0;
              state_nxt    = csnh_pkg::ST_DONE;
              load_div     = 1'b0;
            end else begin
              op_nxt = csnh_pkg::OP_SAT;
            end
          end
          csnh_pkg::OP_SAT: begin
            held_sat_nxt = quo_r[csnh_pkg::PCT_W-1:0];
            op_nxt       = csnh_pkg::OP_HUE;
          end
          csnh_pkg::OP_HUE: begin
            held_hue_nxt = hwrap[csnh_pkg::HUE_W-1:0];
            state_nxt    = csnh_pkg::ST_DONE;
            load_div     = 1'b0;
          end
          default: begin
            state_nxt = csnh_pkg::ST_DONE;
            load_div  = 1'b0;
          end
        endcase
        op_sel = op_nxt;
      end
      csnh_pkg::ST_DONE: begin
        // Hand the held values to the output register once it is free
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.ready_res      = present_r;
          out_data_nxt.reflection_out = held_refl_r;
          out_data_nxt.normalized_out = held_norm_r;
          out_data_nxt.red_out        = held_red_r;
          out_data_nxt.green_out      = held_green_r;
          out_data_nxt.blue_out       = held_blue_r;
          out_data_nxt.hue_deg        = held_hue_r;
          out_data_nxt.saturation_pct = held_sat_r;
          out_data_nxt.value_pct      = held_vpct_r;
          out_data_nxt.value_byte     = held_vbyte_r;
          state_nxt                   = csnh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csnh_pkg::ST_IDLE;
      end
    endcase

    // Start a division on the selected operands
    if (load_div) begin
      num_nxt = op_num;
      den_nxt = op_den;
      neg_nxt = op_neg;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = '0;
    end
  end

  // Configuration writes
  always_comb begin
    black_nxt    = black_r;
    white_nxt    = white_r;
    ro_nxt       = ro_r;
    fallback_nxt = fallback_r;
    clamp_lo_nxt = clamp_lo_r;
    clamp_hi_nxt = clamp_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        csnh_pkg::CFG_BLACK:     black_nxt    = cfg_wdata[CH_W-1:0];
        csnh_pkg::CFG_WHITE:     white_nxt    = cfg_wdata[CH_W-1:0];
        csnh_pkg::CFG_REFL_ONLY: ro_nxt       = cfg_wdata[0];
        csnh_pkg::CFG_FALLBACK:  fallback_nxt = cfg_wdata[csnh_pkg::NORM_W-1:0];
        csnh_pkg::CFG_CLAMP_LO:  clamp_lo_nxt = cfg_wdata[csnh_pkg::NORM_W-1:0];
        csnh_pkg::CFG_CLAMP_HI:  clamp_hi_nxt = cfg_wdata[csnh_pkg::NORM_W-1:0];
        default: begin
          black_nxt = black_r;
        end
      endcase
    end
  end

  // Control, configuration and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= csnh_pkg::ST_IDLE;
      op_r         <= csnh_pkg::OP_NORM;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      black_r      <= CH_W'(0);
      white_r      <= CH_W'(100);
      ro_r         <= 1'b0;
      fallback_r   <= csnh_pkg::NORM_W'(50);
      clamp_lo_r   <= csnh_pkg::NORM_W'(0);
      clamp_hi_r   <= csnh_pkg::NORM_W'(100);
      held_refl_r  <= '0;
      held_norm_r  <= '0;
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
      held_hue_r   <= '0;
      held_sat_r   <= '0;
      held_vpct_r  <= '0;
      held_vbyte_r <= '0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      black_r      <= black_nxt;
      white_r      <= white_nxt;
      ro_r         <= ro_nxt;
      fallback_r   <= fallback_nxt;
      clamp_lo_r   <= clamp_lo_nxt;
      clamp_hi_r   <= clamp_hi_nxt;
      held_refl_r  <= held_refl_nxt;
      held_norm_r  <= held_norm_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      held_blue_r  <= held_blue_nxt;
      held_hue_r   <= held_hue_nxt;
      held_sat_r   <= held_sat_nxt;
      held_vpct_r  <= held_vpct_nxt;
      held_vbyte_r <= held_vbyte_nxt;
    end
  end

  // Divider and output payload
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    neg_r      <= neg_nxt;
    present_r  <= present_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready  = (state_r == csnh_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken again right after a transaction");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csnh_pkg::ST_RUN) && (den_r != '0) |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_hue_r < csnh_pkg::HUE_W'(csnh_pkg::HUE_WRAP))
    else $error("held hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_sat_r <= csnh_pkg::PCT_W'(csnh_pkg::PCT_SCALE))
    else $error("held saturation above one hundred");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csnh_pkg::ST_DONE) && out_free |=> out_valid_r)
    else $error("finished sample not presented");

endmodule

// File: verif/color_sample_normalize_hsv_test.sv
module color_sample_normalize_hsv_test;
  import csnh_pkg::*;

  // Longest quiet stretch of a correct run: long sender gap, a full-mode conversion,
  // long receiver stall, plus the forced receiver hold-off; taken several times over
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS   = 50;
  localparam int RANDOM_PHASES = 11;
  localparam int PRINT_CAP     = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  csnh_in_if  in_if();
  csnh_out_if out_if();

  color_sample_normalize_hsv uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // Shadow of the level registers
  logic [CH_W-1:0]   black_lvl    = CH_W'(0);
  logic [CH_W-1:0]   white_lvl    = CH_W'(100);
  logic              refl_only    = 1'b0;
  logic [NORM_W-1:0] fallback_lvl = NORM_W'(50);
  logic [NORM_W-1:0] clamp_lo     = NORM_W'(0);
  logic [NORM_W-1:0] clamp_hi     = NORM_W'(100);

  // Shadow of the reported values kept between samples
  logic [CH_W-1:0]   held_refl  = '0;
  logic [NORM_W-1:0] held_norm  = '0;
  logic [CH_W-1:0]   held_red   = '0;
  logic [CH_W-1:0]   held_green = '0;
  logic [CH_W-1:0]   held_blue  = '0;
  logic [HUE_W-1:0]  held_hue   = '0;
  logic [PCT_W-1:0]  held_sat   = '0;
  logic [PCT_W-1:0]  held_vpct  = '0;
  logic [BYTE_W-1:0] held_vbyte = '0;

  out_item_t pending_reports[$];
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  bit        no_idle        = 1'b0;
  bit        tight          = 1'b0;
  bit        long_hold_req  = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Normalize reflection and convert channels, updating the held shadow
  function automatic out_item_t convert_sample(input in_item_t item);
    out_item_t rep;
    int span, q, r, g, b, mx, mn, dl, v, hue;
    if (item.sensor_present) begin
      held_refl = item.reflection_raw;
      span = int'(white_lvl) - int'(black_lvl);
      if (span <= 0) begin
        held_norm = fallback_lvl;
      end else begin
        q = ((int'(item.reflection_raw) - int'(black_lvl)) * PCT_SCALE) / span;
        if (q < int'(clamp_lo)) q = int'(clamp_lo);
        if (q > int'(clamp_hi)) q = int'(clamp_hi);
        held_norm = q[NORM_W-1:0];
      end
      if (!refl_only) begin
        held_red   = item.red_in;
        held_green = item.green_in;
        held_blue  = item.blue_in;
        r = int'(item.red_in);
        g = int'(item.green_in);
        b = int'(item.blue_in);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        v = (mx * PCT_SCALE + HALF_FS) / CHANNEL_FULL_SCALE;
        held_vpct = PCT_W'((v > PCT_SCALE) ? PCT_SCALE : v);
        v = (mx * BYTE_SCALE + HALF_FS) / CHANNEL_FULL_SCALE;
        held_vbyte = BYTE_W'((v > BYTE_SCALE) ? BYTE_SCALE : v);
        if (dl == 0) begin
          held_hue = '0;
          held_sat = '0;
        end else begin
          held_sat = PCT_W'((dl * PCT_SCALE + mx / 2) / mx);
          // Red wins ties, then green; division truncates toward zero
          if (mx == r) hue = (HUE_STEP * (g - b)) / dl;
          else if (mx == g) hue = HUE_GREEN + (HUE_STEP * (b - r)) / dl;
          else hue = HUE_BLUE + (HUE_STEP * (r - g)) / dl;
          if (hue < 0) hue += HUE_WRAP;
          held_hue = HUE_W'(hue);
        end
      end
    end else if (!refl_only) begin
      held_refl  = '0;
      held_norm  = '0;
      held_red   = '0;
      held_green = '0;
      held_blue  = '0;
      held_hue   = '0;
      held_sat   = '0;
      held_vpct  = '0;
      held_vbyte = '0;
    end
    rep.ready_res      = item.sensor_present;
    rep.reflection_out = held_refl;
    rep.normalized_out = held_norm;
    rep.red_out        = held_red;
    rep.green_out      = held_green;
    rep.blue_out       = held_blue;
    rep.hue_deg        = held_hue;
    rep.saturation_pct = held_sat;
    rep.value_pct      = held_vpct;
    rep.value_byte     = held_vbyte;
    return rep;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t sample_of(input logic present, input logic [CH_W-1:0] refl,
                                         input logic [CH_W-1:0] r, g, b);
    in_item_t item;
    item.sensor_present = present;
    item.reflection_raw = refl;
    item.red_in         = r;
    item.green_in       = g;
    item.blue_in        = b;
    return item;
  endfunction

  // Bias channels toward the ends of the scale
  function automatic logic [CH_W-1:0] pick_channel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return CH_W'(CH_MAX);
    if (roll < 4) return CH_W'($urandom_range(0, 15));
    return CH_W'($urandom_range(0, CH_MAX));
  endfunction

  function automatic in_item_t random_sample();
    in_item_t item;
    int roll;
    item.sensor_present = ($urandom_range(0, 9) != 0);
    if (white_lvl > black_lvl && $urandom_range(0, 1) == 1)
      item.reflection_raw = CH_W'($urandom_range(int'(black_lvl), int'(white_lvl)));
    else
      item.reflection_raw = CH_W'($urandom_range(0, CH_MAX));
    item.red_in   = pick_channel();
    item.green_in = pick_channel();
    item.blue_in  = pick_channel();
    roll = $urandom_range(0, 9);
    // Force equal channels or a tie on the largest one
    if (roll == 0) begin
      item.green_in = item.red_in;
      item.blue_in  = item.red_in;
    end else if (roll == 1) begin
      item.green_in = item.red_in;
    end else if (roll == 2) begin
      item.blue_in = item.green_in;
    end else if (roll == 3) begin
      item.blue_in = item.red_in;
    end
    return item;
  endfunction

  // Offer one sample and hold it until the transaction completes
  task automatic offer_sample(input in_item_t item);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk); while (!in_if.ready);
    pending_reports.push_back(convert_sample(item));
    gap = tight ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending report has come back
  task automatic wait_for_reports();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six level registers in back-to-back cycles
  task automatic apply_levels(input logic [CH_W-1:0] bl, wl, input logic ro,
                              input logic [NORM_W-1:0] fb, lo, hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLACK;
    cfg_wdata <= CFG_DATA_W'(bl);
    @(posedge clk);
    cfg_index <= CFG_WHITE;
    cfg_wdata <= CFG_DATA_W'(wl);
    @(posedge clk);
    cfg_index <= CFG_REFL_ONLY;
    cfg_wdata <= CFG_DATA_W'(ro);
    @(posedge clk);
    cfg_index <= CFG_FALLBACK;
    cfg_wdata <= CFG_DATA_W'(fb);
    @(posedge clk);
    cfg_index <= CFG_CLAMP_LO;
    cfg_wdata <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_CLAMP_HI;
    cfg_wdata <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    black_lvl    = bl;
    white_lvl    = wl;
    refl_only    = ro;
    fallback_lvl = fb;
    clamp_lo     = lo;
    clamp_hi     = hi;
  endtask

  task automatic test_reset_levels();
    offer_sample(sample_of(1'b1, 10'd50, 10'd1023, 10'd0, 10'd0));
    offer_sample(sample_of(1'b1, 10'd1023, 10'd0, 10'd0, 10'd0));
    offer_sample(sample_of(1'b0, 10'd7, 10'd5, 10'd5, 10'd5));
    wait_for_reports();
  endtask

  task automatic test_channel_extremes();
    apply_levels(10'd0, 10'd1023, 1'b0, 8'd50, 8'd0, 8'd200);
    offer_sample(sample_of(1'b1, 10'd0, 10'd0, 10'd0, 10'd0));
    offer_sample(sample_of(1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
    offer_sample(sample_of(1'b1, 10'd511, 10'd600, 10'd600, 10'd600));
    offer_sample(sample_of(1'b1, 10'd100, 10'd1023, 10'd500, 10'd0));
    // Red largest with blue over green wraps the hue
    offer_sample(sample_of(1'b1, 10'd200, 10'd1023, 10'd0, 10'd500));
    offer_sample(sample_of(1'b1, 10'd300, 10'd0, 10'd1023, 10'd200));
    offer_sample(sample_of(1'b1, 10'd400, 10'd300, 10'd0, 10'd1023));
    offer_sample(sample_of(1'b1, 10'd500, 10'd800, 10'd800, 10'd100));
    offer_sample(sample_of(1'b1, 10'd600, 10'd100, 10'd900, 10'd900));
    offer_sample(sample_of(1'b1, 10'd700, 10'd700, 10'd20, 10'd700));
    offer_sample(sample_of(1'b1, 10'd1, 10'd1, 10'd0, 10'd0));
    offer_sample(sample_of(1'b1, 10'd682, 10'd682, 10'd341, 10'd1));
    wait_for_reports();
  endtask

  task automatic test_empty_range();
    apply_levels(10'd600, 10'd600, 1'b0, 8'd200, 8'd0, 8'd200);
    offer_sample(sample_of(1'b1, 10'd600, 10'd10, 10'd20, 10'd30));
    offer_sample(sample_of(1'b1, 10'd0, 10'd30, 10'd20, 10'd10));
    wait_for_reports();
    apply_levels(10'd900, 10'd10, 1'b0, 8'd0, 8'd0, 8'd100);
    offer_sample(sample_of(1'b1, 10'd1023, 10'd512, 10'd256, 10'd128));
    wait_for_reports();
  endtask

  task automatic test_crossed_clamps();
    apply_levels(10'd0, 10'd1023, 1'b0, 8'd50, 8'd150, 8'd20);
    offer_sample(sample_of(1'b1, 10'd0, 10'd1, 10'd2, 10'd3));
    offer_sample(sample_of(1'b1, 10'd1023, 10'd3, 10'd2, 10'd1));
    wait_for_reports();
  endtask

  task automatic test_reflection_only();
    apply_levels(10'd100, 10'd900, 1'b0, 8'd50, 8'd0, 8'd100);
    offer_sample(sample_of(1'b1, 10'd500, 10'd900, 10'd300, 10'd100));
    wait_for_reports();
    // Colour fields must repeat the values held from the last full sample
    apply_levels(10'd100, 10'd900, 1'b1, 8'd50, 8'd0, 8'd100);
    offer_sample(sample_of(1'b1, 10'd800, 10'd0, 10'd0, 10'd0));
    offer_sample(sample_of(1'b0, 10'd50, 10'd1, 10'd2, 10'd3));
    wait_for_reports();
    // Back in full mode an absent sensor clears everything
    apply_levels(10'd100, 10'd900, 1'b0, 8'd50, 8'd0, 8'd100);
    offer_sample(sample_of(1'b0, 10'd1023, 10'd1023, 10'd1023, 10'd1023));
    offer_sample(sample_of(1'b1, 10'd900, 10'd40, 10'd80, 10'd60));
    wait_for_reports();
  endtask

  task automatic test_spare_index();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    offer_sample(sample_of(1'b1, 10'd450, 10'd250, 10'd750, 10'd500));
    wait_for_reports();
  endtask

  // Hold off the receiver while samples keep coming back to back
  task automatic test_backpressure();
    int n;
    apply_levels(10'd50, 10'd950, 1'b0, 8'd100, 8'd10, 8'd190);
    no_idle       = 1'b0;
    tight         = 1'b1;
    long_hold_req = 1'b1;
    for (n = 0; n < 8; n++) offer_sample(random_sample());
    tight = 1'b0;
    wait_for_reports();
  endtask

  task automatic test_random_traffic();
    int ph, n, kind;
    logic [CH_W-1:0]   bl, wl;
    logic              ro;
    logic [NORM_W-1:0] fb, lo, hi;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        bl = 10'd0; wl = 10'd1023; ro = 1'b0; fb = 8'd0; lo = 8'd0; hi = 8'd200;
      end else if (ph == 1) begin
        bl = 10'd1023; wl = 10'd0; ro = 1'b0; fb = 8'd200; lo = 8'd200; hi = 8'd0;
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          bl = CH_W'($urandom_range(0, 400));
          wl = CH_W'($urandom_range(int'(bl) + 1, CH_MAX));
        end else if (kind < 8) begin
          bl = CH_W'($urandom_range(0, CH_MAX));
          wl = CH_W'($urandom_range(0, int'(bl)));
        end else begin
          bl = CH_W'($urandom_range(0, CH_MAX));
          wl = CH_W'($urandom_range(0, CH_MAX));
        end
        ro = ($urandom_range(0, 3) == 0);
        fb = NORM_W'($urandom_range(0, 200));
        if ($urandom_range(0, 5) == 0) begin
          lo = NORM_W'($urandom_range(100, 200));
          hi = NORM_W'($urandom_range(0, 99));
        end else begin
          lo = NORM_W'($urandom_range(0, 60));
          hi = NORM_W'($urandom_range(80, 200));
        end
      end
      apply_levels(bl, wl, ro, fb, lo, hi);
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) offer_sample(random_sample());
      wait_for_reports();
    end
    no_idle = 1'b0;
  endtask

  initial begin : run_tests
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_levels();
    test_channel_extremes();
    test_empty_range();
    test_crossed_clamps();
    test_reflection_only();
    test_spare_index();
    test_backpressure();
    test_random_traffic();
    wait_for_reports();
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Drive result-side ready with random stalls and one requested long hold-off
  initial begin : report_sink
    int n;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatch_count < PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transaction with the oldest pending report
  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        if (mismatch_count < PRINT_CAP)
          $display("%0t: unexpected report, expected none actual %h", $time, out_if.data);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        report_field("ready_res", int'(want.ready_res), int'(out_if.data.ready_res));
        report_field("reflection_out", int'(want.reflection_out),
                     int'(out_if.data.reflection_out));
        report_field("normalized_out", int'(want.normalized_out),
                     int'(out_if.data.normalized_out));
        report_field("red_out", int'(want.red_out), int'(out_if.data.red_out));
        report_field("green_out", int'(want.green_out), int'(out_if.data.green_out));
        report_field("blue_out", int'(want.blue_out), int'(out_if.data.blue_out));
        report_field("hue_deg", int'(want.hue_deg), int'(out_if.data.hue_deg));
        report_field("saturation_pct", int'(want.saturation_pct),
                     int'(out_if.data.saturation_pct));
        report_field("value_pct", int'(want.value_pct), int'(out_if.data.value_pct));
        report_field("value_byte", int'(want.value_byte), int'(out_if.data.value_byte));
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
